// ----- src/ttcb_pkg.sv -----
// Package for the text terminal character buffer: sizes, character codes,
// register indexes, payload structs and the sequencer state type.
// No dependencies.
package ttcb_pkg;

  // screen geometry of the cell store
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 32;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int CHAR_W   = 8;

  // configuration register widths
  localparam int COLS_CFG_W = 7;
  localparam int ROWS_CFG_W = 6;

  // register indexes (paddr[2])
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  // register reset values
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(MAX_COLS);
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(MAX_ROWS);

  // operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // special character codes
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } ttcb_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
  } ttcb_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_ZERO,
    ST_DONE
  } ttcb_state_e;

endpackage

// ----- src/ttcb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/text_terminal_char_buffer_unit.sv -----
// Top level of the text terminal character buffer: sequencer, cursor,
// configuration registers and result register.
// Depends on ttcb_pkg and ttcb_ram.
//
// Usage: one input word per item on in_data_i (valid/ready), one result
// word per item on out_data_o (valid/ready). A put item stores a character
// at the cursor and advances it; a read item returns one cell.
// After reset the block sweeps the 2048-cell store to zero, one cell per
// cycle, and keeps in_ready_o low until the sweep ends; the APB registers
// can be written meanwhile.
// A read or a put without scroll passes from acceptance through the execute
// and hand-off states to out_valid_o. A scroll runs on the one store port
// pair and the shared counter incrementer: each copied cell is read, then
// written one row up, and then each bottom-row cell is cleared. One item is
// in work at a time; in_ready_o is high only while the sequencer is idle.
// Each word passes through the idle, execute and hand-off states, plus the
// scroll states above when a put scrolls.
// A result waits in the output register while the receiver stalls; the
// next item is accepted meanwhile, and its result is held back until the
// register is free.
module text_terminal_char_buffer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ttcb_pkg::ttcb_in_t           in_data_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ttcb_pkg::ttcb_out_t          out_data_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int RW = ttcb_pkg::ROW_W;
  localparam int CW = ttcb_pkg::COL_W;
  localparam int AW = ttcb_pkg::ADDR_W;

  ttcb_pkg::ttcb_state_e state_q, state_d;

  logic [ttcb_pkg::COLS_CFG_W-1:0] cols_cfg_q;
  logic [ttcb_pkg::ROWS_CFG_W-1:0] rows_cfg_q;

  ttcb_pkg::ttcb_in_t  item_q, item_d;
  ttcb_pkg::ttcb_out_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic          scr_q, scr_d;

  logic [AW-1:0] clr_q, clr_d;
  logic [RW-1:0] sr_q, sr_d;
  logic [CW-1:0] sc_q, sc_d;

  // shared counter incrementer
  logic [AW-1:0] inc_a;
  logic [AW-1:0] inc_y;

  // effective sizes
  logic [ttcb_pkg::COLS_CFG_W-1:0] cols_eff;
  logic [ttcb_pkg::ROWS_CFG_W-1:0] rows_eff;
  logic [CW-1:0]                   last_col;
  logic [RW-1:0]                   last_row;

  // store ports
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ttcb_pkg::CHAR_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [ttcb_pkg::CHAR_W-1:0] ram_rdata;

  // cursor update for a put
  logic [RW-1:0] put_r_cl;
  logic [CW-1:0] put_c_cl;
  logic [RW:0]   put_r1;
  logic [CW:0]   put_c1;
  logic [RW:0]   put_r2;
  logic [CW:0]   put_c2;
  logic          put_scroll;
  logic          is_lf;
  logic          rd_in_range;

  ttcb_ram #(
    .WIDTH(ttcb_pkg::CHAR_W),
    .DEPTH(ttcb_pkg::DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= ttcb_pkg::COLS_RESET;
      rows_cfg_q <= ttcb_pkg::ROWS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        ttcb_pkg::REG_COLS: cols_cfg_q <= pwdata[ttcb_pkg::COLS_CFG_W-1:0];
        ttcb_pkg::REG_ROWS: rows_cfg_q <= pwdata[ttcb_pkg::ROWS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ttcb_pkg::REG_ROWS)
                ? {{(32-ttcb_pkg::ROWS_CFG_W){1'b0}}, rows_cfg_q}
                : {{(32-ttcb_pkg::COLS_CFG_W){1'b0}}, cols_cfg_q};

  // saturate sizes to 1..max
  always_comb begin
    if (cols_cfg_q == '0) begin
      cols_eff = ttcb_pkg::COLS_CFG_W'(1);
    end else if (cols_cfg_q > ttcb_pkg::COLS_CFG_W'(ttcb_pkg::MAX_COLS)) begin
      cols_eff = ttcb_pkg::COLS_CFG_W'(ttcb_pkg::MAX_COLS);
    end else begin
      cols_eff = cols_cfg_q;
    end
    if (rows_cfg_q == '0) begin
      rows_eff = ttcb_pkg::ROWS_CFG_W'(1);
    end else if (rows_cfg_q > ttcb_pkg::ROWS_CFG_W'(ttcb_pkg::MAX_ROWS)) begin
      rows_eff = ttcb_pkg::ROWS_CFG_W'(ttcb_pkg::MAX_ROWS);
    end else begin
      rows_eff = rows_cfg_q;
    end
  end

  assign last_col = CW'(cols_eff - ttcb_pkg::COLS_CFG_W'(1));
  assign last_row = RW'(rows_eff - ttcb_pkg::ROWS_CFG_W'(1));

  // cursor advance for a put: clamp, step, wrap, detect scroll
  always_comb begin
    is_lf    = (item_q.char_code == ttcb_pkg::CH_LF);
    put_r_cl = (cur_row_q > last_row) ? last_row : cur_row_q;
    put_c_cl = (cur_col_q > last_col) ? last_col : cur_col_q;
    if (is_lf) begin
      put_r1 = {1'b0, put_r_cl} + (RW+1)'(1);
      put_c1 = '0;
    end else begin
      put_r1 = {1'b0, put_r_cl};
      put_c1 = {1'b0, put_c_cl} + (CW+1)'(1);
    end
    if (put_c1 >= cols_eff) begin
      put_r2 = put_r1 + (RW+1)'(1);
      put_c2 = '0;
    end else begin
      put_r2 = put_r1;
      put_c2 = put_c1;
    end
    put_scroll = (put_r2 >= rows_eff);
  end

  // read cell lies inside the active area
  assign rd_in_range = ((RW+1)'(item_q.read_row) < rows_eff)
                    && ((CW+1)'(item_q.read_col) < cols_eff);

  // shared incrementer operand select
  always_comb begin
    case (state_q)
      ttcb_pkg::ST_CLEAR:  inc_a = clr_q;
      ttcb_pkg::ST_SCR_RD: inc_a = AW'(sr_q);
      ttcb_pkg::ST_SCR_WR: inc_a = (sc_q == last_col) ? AW'(sr_q) : AW'(sc_q);
      ttcb_pkg::ST_ZERO:   inc_a = AW'(sc_q);
      default:             inc_a = '0;
    endcase
  end

  assign inc_y = inc_a + AW'(1);

  // sequencer state register and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttcb_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      clr_q       <= '0;
      sr_q        <= '0;
      sc_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      clr_q       <= clr_d;
      sr_q        <= sr_d;
      sc_q        <= sc_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
    scr_q  <= scr_d;
  end

  // next state, store access and outputs
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    scr_d       = scr_q;
    clr_d       = clr_q;
    sr_d        = sr_q;
    sc_d        = sc_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    in_ready_o  = 1'b0;

    unique case (state_q)
      // clearing pass over the whole store
      ttcb_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = inc_y;
        if (clr_q == AW'(ttcb_pkg::DEPTH - 1)) begin
          state_d = ttcb_pkg::ST_IDLE;
        end
      end

      ttcb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = ttcb_pkg::ST_EXEC;
        end
      end

      // one put or the read issue
      ttcb_pkg::ST_EXEC: begin
        scr_d   = 1'b0;
        state_d = ttcb_pkg::ST_DONE;
        if (item_q.op == ttcb_pkg::OP_READ) begin
          ram_re    = 1'b1;
          ram_raddr = {item_q.read_row, item_q.read_col};
        end else if (item_q.char_code != ttcb_pkg::CH_CR) begin
          if (!is_lf) begin
            ram_we    = 1'b1;
            ram_waddr = {put_r_cl, put_c_cl};
            ram_wdata = item_q.char_code;
          end
          cur_col_d = put_c2[CW-1:0];
          if (put_scroll) begin
            cur_row_d = last_row;
            scr_d     = 1'b1;
            sr_d      = '0;
            sc_d      = '0;
            state_d   = (last_row == '0) ? ttcb_pkg::ST_ZERO : ttcb_pkg::ST_SCR_RD;
          end else begin
            cur_row_d = put_r2[RW-1:0];
          end
        end
      end

      // scroll: read the cell one row below
      ttcb_pkg::ST_SCR_RD: begin
        ram_re    = 1'b1;
        ram_raddr = {inc_y[RW-1:0], sc_q};
        state_d   = ttcb_pkg::ST_SCR_WR;
      end

      // scroll: write it one row up and step the sweep
      ttcb_pkg::ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {sr_q, sc_q};
        ram_wdata = ram_rdata;
        state_d   = ttcb_pkg::ST_SCR_RD;
        if (sc_q == last_col) begin
          sc_d = '0;
          sr_d = inc_y[RW-1:0];
          if (inc_y[RW:0] == {1'b0, last_row}) begin
            state_d = ttcb_pkg::ST_ZERO;
          end
        end else begin
          sc_d = inc_y[CW-1:0];
        end
      end

      // scroll: clear the bottom row
      ttcb_pkg::ST_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = {last_row, sc_q};
        sc_d      = inc_y[CW-1:0];
        if (sc_q == last_col) begin
          state_d = ttcb_pkg::ST_DONE;
        end
      end

      // hand the result word to the output register when it is free
      ttcb_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.read_char   = ((item_q.op == ttcb_pkg::OP_READ) && rd_in_range)
                            ? ram_rdata : '0;
          out_d.cursor_row  = cur_row_q;
          out_d.cursor_col  = cur_col_q;
          out_d.scrolled    = (item_q.op == ttcb_pkg::OP_PUT) && scr_q;
          state_d           = ttcb_pkg::ST_IDLE;
        end
      end

      default: state_d = ttcb_pkg::ST_CLEAR;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a scrolled result leaves the cursor on the bottom active row
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.scrolled) |-> (out_data_o.cursor_row == last_row))
    else $error("scrolled result with cursor off the bottom row");

  // the copy sweep never reaches the bottom row
  a_copy_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ttcb_pkg::ST_SCR_WR) |-> (sr_q < last_row))
    else $error("scroll copy past the bottom row");

  // no store write while waiting for an item
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ttcb_pkg::ST_IDLE) |-> !ram_we)
    else $error("store written while idle");

  // a new result word only comes out of the result hand-off step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ttcb_pkg::ST_DONE))
    else $error("result raised outside hand-off");

endmodule

// ----- test/tb_top.sv -----
// Testbench for text_terminal_char_buffer_unit: directed and random put/read
// words checked against a behavioral screen image kept in the bench.
// Depends on ttcb_pkg and the text_terminal_char_buffer_unit RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // clock, reset and ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  ttcb_pkg::ttcb_in_t   in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  ttcb_pkg::ttcb_out_t  out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  // screen image, cursor and size registers as the bench sees them
  logic [ttcb_pkg::CHAR_W-1:0]     screen_img [ttcb_pkg::MAX_ROWS][ttcb_pkg::MAX_COLS];
  int unsigned                     cur_row;
  int unsigned                     cur_col;
  logic [ttcb_pkg::COLS_CFG_W-1:0] cfg_cols;
  logic [ttcb_pkg::ROWS_CFG_W-1:0] cfg_rows;

  ttcb_pkg::ttcb_out_t pending_results [$];

  bit idle_on;
  int err_cnt;
  int n_items;
  int n_reads;
  int n_scrolls;
  int n_reg_writes;
  int unsigned hold;

  always #5 clk_i = ~clk_i;

  text_terminal_char_buffer_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // size in use: zero acts as one, above the maximum saturates
  function automatic int unsigned used_cols();
    if (cfg_cols == 0) return 1;
    if (cfg_cols > ttcb_pkg::MAX_COLS) return ttcb_pkg::MAX_COLS;
    return 32'(cfg_cols);
  endfunction

  function automatic int unsigned used_rows();
    if (cfg_rows == 0) return 1;
    if (cfg_rows > ttcb_pkg::MAX_ROWS) return ttcb_pkg::MAX_ROWS;
    return 32'(cfg_rows);
  endfunction

  // shift the active area up one row and blank its bottom row
  function automatic void scroll_screen(int unsigned rows, int unsigned cols);
    for (int r = 0; r + 1 < rows; r++)
      for (int c = 0; c < cols; c++)
        screen_img[r][c] = screen_img[r+1][c];
    for (int c = 0; c < cols; c++)
      screen_img[rows-1][c] = '0;
  endfunction

  // apply one word to the screen image and return the result it should give
  function automatic ttcb_pkg::ttcb_out_t screen_step(ttcb_pkg::ttcb_in_t w);
    int unsigned         cols;
    int unsigned         rows;
    int unsigned         r;
    int unsigned         c;
    ttcb_pkg::ttcb_out_t res;
    cols = used_cols();
    rows = used_rows();
    res  = '0;
    if (w.op == ttcb_pkg::OP_READ) begin
      if (w.read_row < rows && w.read_col < cols)
        res.read_char = screen_img[w.read_row][w.read_col];
    end else if (w.char_code != ttcb_pkg::CH_CR) begin
      // a cursor left outside a shrunk screen is pulled back in first
      r = (cur_row > rows - 1) ? rows - 1 : cur_row;
      c = (cur_col > cols - 1) ? cols - 1 : cur_col;
      if (w.char_code == ttcb_pkg::CH_LF) begin
        r++;
        c = 0;
      end else begin
        screen_img[r][c] = w.char_code;
        c++;
      end
      if (c >= cols) begin
        r++;
        c = 0;
      end
      if (r >= rows) begin
        r = rows - 1;
        scroll_screen(rows, cols);
        res.scrolled = 1'b1;
        n_scrolls++;
      end
      cur_row = r;
      cur_col = c;
    end
    res.cursor_row = ttcb_pkg::ROW_W'(cur_row);
    res.cursor_col = ttcb_pkg::COL_W'(cur_col);
    return res;
  endfunction

  // send one word; returns at the falling edge after acceptance with valid still high
  task automatic send_word(ttcb_pkg::ttcb_in_t w);
    ttcb_pkg::ttcb_out_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_data_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    want = screen_step(w);
    pending_results = {pending_results, want};
    n_items++;
    if (w.op == ttcb_pkg::OP_READ) n_reads++;
    @(negedge clk_i);
  endtask

  task automatic put_char(logic [ttcb_pkg::CHAR_W-1:0] ch);
    ttcb_pkg::ttcb_in_t w;
    w = '0;
    w.op = ttcb_pkg::OP_PUT;
    w.char_code = ch;
    send_word(w);
  endtask

  task automatic read_cell(int unsigned row, int unsigned col);
    ttcb_pkg::ttcb_in_t w;
    w = '0;
    w.op = ttcb_pkg::OP_READ;
    w.read_row = ttcb_pkg::ROW_W'(row);
    w.read_col = ttcb_pkg::COL_W'(col);
    send_word(w);
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // apb write then read back; random upper bits must be ignored
  task automatic write_reg(logic idx, logic [31:0] value);
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == ttcb_pkg::REG_COLS) cfg_cols = value[ttcb_pkg::COLS_CFG_W-1:0];
    else cfg_rows = value[ttcb_pkg::ROWS_CFG_W-1:0];
    n_reg_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == ttcb_pkg::REG_COLS ? got[ttcb_pkg::COLS_CFG_W-1:0] !== cfg_cols
                                  : got[ttcb_pkg::ROWS_CFG_W-1:0] !== cfg_rows) begin
      $display("%0t register %0d readback: expected %0h actual %0h", $time, idx,
               (idx == ttcb_pkg::REG_COLS) ? 32'(cfg_cols) : 32'(cfg_rows), got);
      err_cnt++;
    end
  endtask

  task automatic set_screen(int unsigned cols, int unsigned rows);
    write_reg(ttcb_pkg::REG_COLS, ($urandom & ~32'h7f) | (cols & 32'h7f));
    write_reg(ttcb_pkg::REG_ROWS, ($urandom & ~32'h3f) | (rows & 32'h3f));
  endtask

  function automatic ttcb_pkg::ttcb_in_t random_word(int lf_pct);
    ttcb_pkg::ttcb_in_t w;
    int                 pick;
    w.char_code = ttcb_pkg::CHAR_W'($urandom);
    w.read_row  = ttcb_pkg::ROW_W'($urandom);
    w.read_col  = ttcb_pkg::COL_W'($urandom);
    if ($urandom_range(0, 99) < 30) begin
      w.op = ttcb_pkg::OP_READ;
      // mostly cells on screen, some anywhere
      if ($urandom_range(0, 3) != 0) begin
        w.read_row = ttcb_pkg::ROW_W'($urandom_range(0, used_rows() - 1));
        w.read_col = ttcb_pkg::COL_W'($urandom_range(0, used_cols() - 1));
      end
    end else begin
      w.op = ttcb_pkg::OP_PUT;
      pick = $urandom_range(0, 99);
      if (pick < lf_pct) w.char_code = ttcb_pkg::CH_LF;
      else if (pick < lf_pct + 5) w.char_code = ttcb_pkg::CH_CR;
    end
    return w;
  endfunction

  // cleared store, extreme cells and extreme character codes
  task automatic test_power_up();
    read_cell(ttcb_pkg::MAX_ROWS - 1, ttcb_pkg::MAX_COLS - 1);
    read_cell(0, 0);
    put_char(8'hff);
    put_char(8'h00);
    read_cell(0, 0);
    drain();
  endtask

  // wrap at the last column, carriage return, line feed and scrolling
  task automatic test_wrap_and_scroll();
    set_screen(3, 2);
    put_char("A");
    put_char(ttcb_pkg::CH_CR);
    put_char("B");
    put_char("C");
    put_char("D");
    put_char(ttcb_pkg::CH_LF);
    read_cell(0, 0);
    read_cell(0, 2);
    read_cell(2, 0);
    read_cell(0, 3);
    drain();
  endtask

  // zero sizes act as one, oversized registers saturate, hidden cells return
  task automatic test_size_saturation();
    set_screen(0, 0);
    put_char("q");
    read_cell(0, 0);
    drain();
    set_screen(127, 63);
    read_cell(1, 1);
    read_cell(ttcb_pkg::MAX_ROWS - 1, ttcb_pkg::MAX_COLS - 1);
    drain();
  endtask

  // cursor beyond a shrunk screen is clamped on the next put
  task automatic test_cursor_clamp();
    put_char(ttcb_pkg::CH_LF);
    put_char(ttcb_pkg::CH_LF);
    put_char(ttcb_pkg::CH_LF);
    put_char("k");
    put_char("k");
    drain();
    set_screen(2, 2);
    put_char("m");
    read_cell(0, 1);
    drain();
  endtask

  task automatic run_screen_phase(int unsigned cols, int unsigned rows, int count,
                                  int lf_pct);
    set_screen(cols, rows);
    repeat (count) send_word(random_word(lf_pct));
    drain();
  endtask

  // random text on a range of screen sizes, extremes included
  task automatic test_random_screens();
    run_screen_phase(1, 1, 80, 10);
    run_screen_phase(ttcb_pkg::MAX_COLS, ttcb_pkg::MAX_ROWS, 120, 10);
    run_screen_phase(ttcb_pkg::MAX_COLS, ttcb_pkg::MAX_ROWS, 60, 80);
    run_screen_phase(127, 63, 60, 10);
    run_screen_phase(0, 0, 40, 10);
    repeat (4) run_screen_phase($urandom_range(1, 12), $urandom_range(1, 8), 80, 10);
  endtask

  // back to back words with the receiver always ready
  task automatic test_steady_stream();
    idle_on = 1'b0;
    run_screen_phase($urandom_range(1, 16), $urandom_range(1, 8), 100, 10);
  endtask

  // receiver stalls in random bursts while idling is on
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 16);
        out_ready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
      err_cnt++;
    end
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    ttcb_pkg::ttcb_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result word: expected none actual %0h", $time,
                 out_data_o);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_char", 32'(want.read_char), 32'(out_data_o.read_char));
        check_field("cursor_row", 32'(want.cursor_row), 32'(out_data_o.cursor_row));
        check_field("cursor_col", 32'(want.cursor_col), 32'(out_data_o.cursor_col));
        check_field("scrolled", 32'(want.scrolled), 32'(out_data_o.scrolled));
      end
    end
  end

  // run limit: every word scrolling a full screen with maximum idling, several times over
  initial begin
    #200ms;
    $display("text_terminal_char_buffer_unit verification failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_on     = 1'b1;
    cur_row     = 0;
    cur_col     = 0;
    cfg_cols    = ttcb_pkg::COLS_RESET;
    cfg_rows    = ttcb_pkg::ROWS_RESET;
    foreach (screen_img[r, c]) screen_img[r][c] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_power_up();
    test_wrap_and_scroll();
    test_size_saturation();
    test_cursor_clamp();
    test_random_screens();
    test_steady_stream();

    drain();
    repeat (100) @(negedge clk_i);
    $display("ran %0d words (%0d reads, %0d puts) with %0d scrolls", n_items, n_reads,
             n_items - n_reads, n_scrolls);
    $display("screen sizes changed through %0d register writes", n_reg_writes);
    if (err_cnt == 0) begin
      $display("text_terminal_char_buffer_unit verification clean");
    end else begin
      $display("text_terminal_char_buffer_unit verification failed");
    end
    $finish;
  end

endmodule
